FILE: hw/rtl/perc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// perc_pkg
// Shared types and constants of the percent decoder.
// ----------------------------------------------------------------------------
package perc_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 12;
    localparam int MAX_RES = 3;
    localparam int NUM_W   = 2;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [LEN_W-1:0] LIMIT_RESET = 12'd255;

    // character codes
    localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h66;
    localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UF    = 8'h46;
    localparam logic [BYTE_W-1:0] HEX_TEN  = 8'd10;

    // escape sequence phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    // one result item
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic              done;
        logic [LEN_W-1:0]  len;
    } t_res;

    // all results caused by one input item
    typedef struct packed {
        logic [NUM_W-1:0]          num;
        t_res [MAX_RES-1:0]        ent;
    } t_cmd;

    // push side of the command queue
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

FILE: hw/rtl/perc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// perc_front
// Accepts characters, tracks the escape phase and the emitted count, and
// turns each item into a command of up to three result items.
// ----------------------------------------------------------------------------
module perc_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [perc_pkg::BYTE_W-1:0]  i_in_byte,
    input  wire logic                         i_end_of_string,
    input  wire logic                         i_cfg_valid,
    input  wire logic [perc_pkg::LEN_W-1:0]   i_cfg_data,
    input  wire perc_pkg::t_qstat             i_qstat,
    output perc_pkg::t_push                   o_push
);

    typedef struct packed {
        perc_pkg::t_cmd                cmd;
        logic [perc_pkg::LEN_W-1:0]    cnt;
    } t_work;

    function automatic logic f_is_hex(input logic [perc_pkg::BYTE_W-1:0] c);
        f_is_hex = (c >= perc_pkg::CH_0  && c <= perc_pkg::CH_9)  ||
                   (c >= perc_pkg::CH_LA && c <= perc_pkg::CH_LF) ||
                   (c >= perc_pkg::CH_UA && c <= perc_pkg::CH_UF);
    endfunction

    function automatic logic [3:0] f_hex_val(input logic [perc_pkg::BYTE_W-1:0] c);
        logic [perc_pkg::BYTE_W-1:0] v;
        if (c >= perc_pkg::CH_LA && c <= perc_pkg::CH_LF) begin
            v = c - perc_pkg::CH_LA + perc_pkg::HEX_TEN;
        end else if (c >= perc_pkg::CH_UA && c <= perc_pkg::CH_UF) begin
            v = c - perc_pkg::CH_UA + perc_pkg::HEX_TEN;
        end else begin
            v = c - perc_pkg::CH_0;
        end
        f_hex_val = v[3:0];
    endfunction

    // append one decoded byte unless the limit is reached
    function automatic t_work f_emit(input t_work w,
                                     input logic [perc_pkg::BYTE_W-1:0] b,
                                     input logic [perc_pkg::LEN_W-1:0] limit);
        t_work r;
        r = w;
        if (w.cnt < limit) begin
            r.cnt = w.cnt + 1'b1;
            r.cmd.ent[w.cmd.num] = '{data: b, valid: 1'b1, done: 1'b0, len: r.cnt};
            r.cmd.num = w.cmd.num + 1'b1;
        end
        return r;
    endfunction

    perc_pkg::t_phase               r_phase, n_phase;
    logic [perc_pkg::BYTE_W-1:0]    r_held, n_held;
    logic [perc_pkg::LEN_W-1:0]     r_count, n_count;
    logic [perc_pkg::LEN_W-1:0]     r_limit;
    logic                           s_accept;
    t_work                          s_work;
    perc_pkg::t_phase               s_phase;
    logic [perc_pkg::BYTE_W-1:0]    s_held;
    logic [perc_pkg::LEN_W-1:0]     s_count;

    assign o_stall  = i_qstat.full;
    assign s_accept = i_valid && !o_stall;

    // classify the item and build its results
    always_comb begin
        logic go;
        go      = 1'b0;
        s_work  = '{cmd: '0, cnt: r_count};
        s_phase = r_phase;
        s_held  = r_held;
        s_count = r_count;
        if (i_end_of_string) begin
            case (r_phase)
                perc_pkg::PH_PCT: begin
                    s_work = f_emit(s_work, perc_pkg::CH_PCT, r_limit);
                end
                perc_pkg::PH_DIGIT: begin
                    s_work = f_emit(s_work, perc_pkg::CH_PCT, r_limit);
                    s_work = f_emit(s_work, r_held, r_limit);
                end
                default: begin
                end
            endcase
            s_work.cmd.ent[s_work.cmd.num] = '{data: '0, valid: 1'b0, done: 1'b1,
                                                len: s_work.cnt};
            s_work.cmd.num = s_work.cmd.num + 1'b1;
            s_phase = perc_pkg::PH_IDLE;
            s_held  = '0;
            s_count = '0;
        end else begin
            if (r_count < r_limit) begin
                go = 1'b1;
                case (r_phase)
                    perc_pkg::PH_PCT: begin
                        if (f_is_hex(i_in_byte)) begin
                            s_held  = i_in_byte;
                            s_phase = perc_pkg::PH_DIGIT;
                            go      = 1'b0;
                        end else begin
                            s_work  = f_emit(s_work, perc_pkg::CH_PCT, r_limit);
                            s_phase = perc_pkg::PH_IDLE;
                        end
                    end
                    perc_pkg::PH_DIGIT: begin
                        if (f_is_hex(i_in_byte)) begin
                            s_work = f_emit(s_work,
                                            {f_hex_val(r_held), f_hex_val(i_in_byte)},
                                            r_limit);
                            go     = 1'b0;
                        end else begin
                            s_work = f_emit(s_work, perc_pkg::CH_PCT, r_limit);
                            s_work = f_emit(s_work, r_held, r_limit);
                        end
                        s_phase = perc_pkg::PH_IDLE;
                        s_held  = '0;
                    end
                    default: begin
                        s_phase = perc_pkg::PH_IDLE;
                    end
                endcase
                if (go && s_work.cnt < r_limit) begin
                    if (i_in_byte == perc_pkg::CH_PCT) begin
                        s_phase = perc_pkg::PH_PCT;
                    end else begin
                        s_work = f_emit(s_work, i_in_byte, r_limit);
                    end
                end
            end
            s_count = s_work.cnt;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_count = r_count;
        if (s_accept) begin
            n_phase = s_phase;
            n_held  = s_held;
            n_count = s_count;
        end
    end

    // push commands that carry results
    always_comb begin
        o_push.valid = s_accept && (s_work.cmd.num != '0);
        o_push.cmd   = s_work.cmd;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= perc_pkg::PH_IDLE;
            r_held  <= '0;
            r_count <= '0;
            r_limit <= perc_pkg::LIMIT_RESET;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_count <= n_count;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/perc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// perc_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module perc_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire perc_pkg::t_push   i_push,
    input  wire logic              i_pop,
    output perc_pkg::t_cmd         o_head,
    output perc_pkg::t_qstat       o_qstat
);

    perc_pkg::t_cmd                 r_mem [perc_pkg::QDEPTH];
    logic [perc_pkg::QPTR_W-1:0]    r_wptr, n_wptr;
    logic [perc_pkg::QPTR_W-1:0]    r_rptr, n_rptr;
    logic [perc_pkg::QCNT_W-1:0]    r_cnt, n_cnt;
    logic                           s_push;
    logic                           s_pop;

    assign o_qstat.full  = (r_cnt == perc_pkg::QCNT_W'(perc_pkg::QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign o_head        = r_mem[r_rptr];

    assign s_push = i_push.valid && !o_qstat.full;
    assign s_pop  = i_pop && !o_qstat.empty;

    // pointer and fill update
    always_comb begin
        n_wptr = s_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = s_pop  ? r_rptr + 1'b1 : r_rptr;
        n_cnt  = r_cnt;
        if (s_push && !s_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (s_pop && !s_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wptr] <= i_push.cmd;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/perc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// perc_back
// Walks the results of the head command one per cycle into the output
// register while the output is not stalled.
// ----------------------------------------------------------------------------
module perc_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire perc_pkg::t_cmd                i_head,
    input  wire perc_pkg::t_qstat              i_qstat,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [perc_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                               o_byte_valid,
    output logic                               o_done_res,
    output logic [perc_pkg::LEN_W-1:0]         o_out_length
);

    logic [perc_pkg::NUM_W-1:0]  r_idx, n_idx;
    logic                        r_valid, n_valid;
    perc_pkg::t_res              r_res;
    logic                        s_load;
    logic                        s_take;
    logic                        s_last;

    assign s_load = !r_valid || !i_stall;
    assign s_take = s_load && !i_qstat.empty;
    assign s_last = (r_idx + 1'b1) == i_head.num;
    assign o_pop  = s_take && s_last;

    // entry index and output valid
    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (s_take) begin
            n_valid = 1'b1;
            n_idx   = s_last ? '0 : r_idx + 1'b1;
        end else if (s_load) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_res <= i_head.ent[r_idx];
        end
    end

    assign o_valid      = r_valid;
    assign o_out_byte   = r_res.data;
    assign o_byte_valid = r_res.valid;
    assign o_done_res   = r_res.done;
    assign o_out_length = r_res.len;

endmodule

`default_nettype wire

FILE: hw/rtl/percent_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// percent_decoder
// Streaming URL percent decoder, one character per input item.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  i_valid / o_stall carries i_in_byte and i_end_of_string;
//   an item with i_end_of_string set closes the string.
//   output channel o_valid / i_stall carries one result item per transfer:
//   a decoded byte, or the final item with o_done_res set and the length.
//   i_cfg_valid / o_cfg_ready writes the output limit (ready is always high).
// Timing:
//   one input item per cycle; each item yields zero to three result items
//   that leave the output register at one per cycle while i_stall is low,
//   passing the queue storage and then the output register. Sustained input
//   rate is one item per cycle while items give at most one result; the
//   single output port sets the rate otherwise. A four-entry command queue
//   sits between the front and the back, so input stalls only when it fills.
// Reset:
//   synchronous, active low; clears the phase, count and queue and sets the
//   limit to 255. A stalled output holds its item while the front keeps
//   accepting until the queue is full.
// ----------------------------------------------------------------------------
module percent_decoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [perc_pkg::BYTE_W-1:0]   i_in_byte,
    input  wire logic                          i_end_of_string,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [perc_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                               o_byte_valid,
    output logic                               o_done_res,
    output logic [perc_pkg::LEN_W-1:0]         o_out_length,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [perc_pkg::LEN_W-1:0]    i_cfg_data
);

    perc_pkg::t_push   s_push;
    perc_pkg::t_cmd    s_head;
    perc_pkg::t_qstat  s_qstat;
    logic              s_pop;

    assign o_cfg_ready = 1'b1;

    // classification and state
    perc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .i_cfg_valid     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_qstat         (s_qstat),
        .o_push          (s_push)
    );

    // command queue
    perc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_pop   (s_pop),
        .o_head  (s_head),
        .o_qstat (s_qstat)
    );

    // result serializer
    perc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (s_head),
        .i_qstat      (s_qstat),
        .o_pop        (s_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_done_res   (o_done_res),
        .o_out_length (o_out_length)
    );

endmodule

`default_nettype wire
